[rtl/core/mrf_pkg.sv]
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared constants, types and the CRC-16 step of the response framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int MAX_REGS    = 32;
    localparam int STORE_DEPTH = 2 * MAX_REGS + 8;
    localparam int BANK_DEPTH  = STORE_DEPTH / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH);
    localparam int WORD_W      = $clog2(MAX_REGS + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_ECHO   = 3'd1;
    localparam logic [2:0] KIND_BADFN  = 3'd2;
    localparam logic [2:0] KIND_CRCERR = 3'd3;
    localparam logic [2:0] KIND_LENERR = 3'd4;

    localparam logic CFG_READ_CODE  = 1'b0;
    localparam logic CFG_WRITE_CODE = 1'b1;

    typedef struct packed {
        logic       take_byte;
        logic       restart;
        logic       word_clr;
        logic       rd_issue;
        logic       word_inc;
        logic       load;
        logic [2:0] kind;
    } t_dp_cmd;

    typedef struct packed {
        logic len_err;
        logic complete;
        logic crc_ok;
        logic is_write;
        logic is_read;
        logic no_words;
        logic last_word;
        logic out_free;
    } t_dp_stat;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/modbus_rtu_response_framer.sv]
// A received byte is transferred in the idle state and judged in the judge state,
// which waits while the output register is full; a clear is taken in idle alone.
// A single result is loaded from the judge state once the output register is free;
// each word of a read response passes the request state, then the output state,
// as the two banks are read through registers. Reset is synchronous, active low;
// it resets control state and function codes; the store needs no clearing pass.
// ----------------------------------------------------------------------------
// modbus_rtu_response_framer
// Collects one response frame byte by byte, checks its CRC-16 and length, and
// emits register values, a write echo or an error result.
// ----------------------------------------------------------------------------
module modbus_rtu_response_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_reg_addr,
    output logic [15:0] o_value,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import mrf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mrf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_reg_addr  (o_reg_addr),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule

[rtl/core/mrf_datapath.sv]
// ----------------------------------------------------------------------------
// mrf_datapath
// Frame store in two byte banks, running CRC, header capture, configuration
// registers, word walk counter and the output register.
// ----------------------------------------------------------------------------
module mrf_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mrf_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_out_ready,
    output mrf_pkg::t_dp_stat o_stat,
    output logic             o_out_valid,
    output logic [2:0]       o_kind,
    output logic [15:0]      o_reg_addr,
    output logic [15:0]      o_value,
    output logic             o_last
);
    import mrf_pkg::*;

    logic [7:0]         r_even_bank [BANK_DEPTH];
    logic [7:0]         r_odd_bank  [BANK_DEPTH];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_code, r_cnt, r_b3, r_b4, r_b5;
    logic [7:0]         r_read_code, r_write_code;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [7:0]         r_hi, r_lo;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_kind;
    logic [15:0]        r_reg_addr, r_value;
    logic               r_last;

    logic [BANK_AW-1:0] wr_idx;
    logic [BANK_AW-1:0] hi_idx, lo_idx;
    logic [8:0]         exp_len;
    logic [6:0]         words;
    logic               is_write, is_read;

    assign wr_idx   = BANK_AW'(r_count >> 1);
    assign hi_idx   = BANK_AW'(r_word) + BANK_AW'(1);
    assign lo_idx   = BANK_AW'(r_word) + BANK_AW'(2);
    assign is_write = (r_code == r_write_code);
    assign is_read  = !is_write && (r_code == r_read_code);
    assign words    = r_cnt[7:1];

    always_comb begin
        if (is_write) begin
            exp_len = 9'd8;
        end else if (is_read) begin
            exp_len = 9'd5 + {1'b0, r_cnt};
        end else begin
            exp_len = 9'd6;
        end
    end

    always_comb begin
        o_stat.is_write  = is_write;
        o_stat.is_read   = is_read;
        o_stat.crc_ok    = (r_crc == 16'h0000);
        o_stat.complete  = (r_count >= CNT_W'(6)) && (9'(r_count) == exp_len);
        o_stat.len_err   = (r_count == CNT_W'(6)) && is_read &&
                           ((r_cnt == 8'd0) || (9'(r_cnt) > 9'(2 * MAX_REGS)));
        o_stat.no_words  = (words == 7'd0);
        o_stat.last_word = ((8'(r_word) + 8'd1) == 8'(words));
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (i_cmd.restart) begin
            n_count = '0;
            n_crc   = CRC_INIT;
        end else if (i_cmd.take_byte) begin
            n_count = r_count + CNT_W'(1);
            n_crc   = crc_update(r_crc, i_rx_byte);
        end
        n_word = r_word;
        if (i_cmd.word_clr) begin
            n_word = '0;
        end else if (i_cmd.word_inc) begin
            n_word = r_word + WORD_W'(1);
        end
        n_out_valid = r_out_valid;
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_crc        <= CRC_INIT;
            r_word       <= '0;
            r_out_valid  <= 1'b0;
            r_read_code  <= 8'd3;
            r_write_code <= 8'd6;
        end else begin
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_READ_CODE:  r_read_code  <= i_cfg_data;
                    CFG_WRITE_CODE: r_write_code <= i_cfg_data;
                    default:        r_read_code  <= r_read_code;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            if (r_count[0]) begin
                r_odd_bank[wr_idx] <= i_rx_byte;
            end else begin
                r_even_bank[wr_idx] <= i_rx_byte;
            end
            case (r_count)
                CNT_W'(1): r_code <= i_rx_byte;
                CNT_W'(2): r_cnt  <= i_rx_byte;
                CNT_W'(3): r_b3   <= i_rx_byte;
                CNT_W'(4): r_b4   <= i_rx_byte;
                CNT_W'(5): r_b5   <= i_rx_byte;
                default:   r_b5   <= r_b5;
            endcase
        end
        if (i_cmd.rd_issue) begin
            r_hi <= r_odd_bank[hi_idx];
            r_lo <= r_even_bank[lo_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_cmd.kind;
            case (i_cmd.kind)
                KIND_READ: begin
                    r_reg_addr <= 16'h0000;
                    r_value    <= {r_hi, r_lo};
                    r_last     <= o_stat.last_word;
                end
                KIND_ECHO: begin
                    r_reg_addr <= {r_cnt, r_b3};
                    r_value    <= {r_b4, r_b5};
                    r_last     <= 1'b1;
                end
                default: begin
                    r_reg_addr <= 16'h0000;
                    r_value    <= 16'h0000;
                    r_last     <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_reg_addr  = r_reg_addr;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

[rtl/core/mrf_ctrl.sv]
// ----------------------------------------------------------------------------
// mrf_ctrl
// Controller: takes bytes, judges the frame and walks the stored words.
// ----------------------------------------------------------------------------
module mrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_operation,
    output logic              o_in_ready,
    input  mrf_pkg::t_dp_stat i_stat,
    output mrf_pkg::t_dp_cmd  o_cmd
);
    import mrf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_JUDGE = 4'b0010,
        S_RDREQ = 4'b0100,
        S_RDOUT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.kind = KIND_READ;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_operation) begin
                        o_cmd.restart = 1'b1;
                    end else begin
                        o_cmd.take_byte = 1'b1;
                        n_state         = S_JUDGE;
                    end
                end
            end
            S_JUDGE: begin
                if (i_stat.len_err) begin
                    if (i_stat.out_free) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.kind    = KIND_LENERR;
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_stat.complete) begin
                    if (i_stat.crc_ok && i_stat.is_read && !i_stat.is_write) begin
                        if (i_stat.no_words) begin
                            o_cmd.restart = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.word_clr = 1'b1;
                            n_state        = S_RDREQ;
                        end
                    end else if (i_stat.out_free) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                        if (!i_stat.crc_ok) begin
                            o_cmd.kind = KIND_CRCERR;
                        end else if (i_stat.is_write) begin
                            o_cmd.kind = KIND_ECHO;
                        end else begin
                            o_cmd.kind = KIND_BADFN;
                        end
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RDREQ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RDOUT;
            end
            S_RDOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.kind     = KIND_READ;
                    o_cmd.word_inc = 1'b1;
                    if (i_stat.last_word) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_RDREQ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
